FILE: sv/smmd_pkg.sv
// ----------------------------------------------------------------------------
// smmd_pkg: shared types and constants of the memory map decoder
// Request and response layouts, command codes, region entry and chain token.
// ----------------------------------------------------------------------------
package smmd_pkg;

	localparam int unsigned MAX_REGIONS_DEF = 8;
	localparam int unsigned CFG_IDX_W       = 4;

	// request types
	localparam logic [1:0] REQ_DECODE = 2'd0;
	localparam logic [1:0] REQ_APPEND = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;

	// access kinds
	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_FETCH = 2'd2;

	// access sizes
	localparam logic [2:0] FETCH_BYTES = 3'd2;
	localparam logic [2:0] SIZE_MIN    = 3'd1;
	localparam logic [2:0] SIZE_MAX    = 3'd4;
	localparam logic [2:0] SIZE_HALF   = 3'd2;

	// system control space
	localparam logic [31:0] SCS_LO = 32'hE000_E000;
	localparam logic [31:0] SCS_HI = 32'hE001_0000;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FLASH_SEC_BASE  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FLASH_SEC_LEN   = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FLASH_NSEC_BASE = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FLASH_NSEC_LEN  = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RAM_SEC_BASE    = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_RAM_SEC_LEN     = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_RAM_NSEC_BASE   = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_RAM_NSEC_LEN    = 4'd7;

	typedef enum logic [1:0] {
		TGT_FLASH,
		TGT_RAM,
		TGT_MMIO,
		TGT_FAULT
	} tgt_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PRE,
		ST_RUN,
		ST_FIN
	} st_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [1:0]  access_kind;
		logic [31:0] addr;
		logic [2:0]  access_bytes;
		logic [31:0] region_sec_base;
		logic [31:0] region_nsec_base;
		logic [31:0] region_len;
	} req_t;

	typedef struct packed {
		logic [1:0]  target;
		logic [31:0] byte_offset;
		logic        flash_nsec_hit;
		logic        in_scs;
	} rsp_t;

	// one RAM region; only the low 32 bits of its running offset reach the result
	typedef struct packed {
		logic [31:0] sec_base;
		logic [31:0] nsec_base;
		logic [31:0] len;
		logic [31:0] off;
	} region_t;

	// lookup token walking down the region chain
	typedef struct packed {
		logic        live;
		logic        hit;
		logic [31:0] off;
	} tok_t;

	// a >= base and a - base + sz <= len, at 33 bits
	function automatic logic in_window(input logic [31:0] a, input logic [2:0] sz,
			input logic [31:0] base, input logic [31:0] len);
		logic [32:0] span;
		span = {1'b0, a - base} + {30'd0, sz};
		return (a >= base) && (span <= {1'b0, len});
	endfunction

endpackage

FILE: sv/smmd_cell.sv
// ----------------------------------------------------------------------------
// smmd_cell: one RAM region slot of the lookup chain
// Holds a region entry and matches the passing token against both aliases.
// ----------------------------------------------------------------------------
module smmd_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  smmd_pkg::region_t wr_region,
	input  logic             used,
	input  logic [31:0]      addr,
	input  logic [2:0]       sz,
	input  smmd_pkg::tok_t   tok_in,
	output smmd_pkg::tok_t   tok_out
);
	import smmd_pkg::*;

	region_t     region_q;
	tok_t        tok_q;
	tok_t        tok_nxt;
	logic        sec_hit;
	logic        nsec_hit;
	logic [31:0] delta;

	always_ff @(posedge clk) begin
		if (wr) begin
			region_q <= wr_region;
		end
	end

	always_comb begin
		sec_hit  = used && in_window(addr, sz, region_q.sec_base, region_q.len);
		nsec_hit = used && in_window(addr, sz, region_q.nsec_base, region_q.len);
		delta    = sec_hit ? (addr - region_q.sec_base) : (addr - region_q.nsec_base);
		tok_nxt  = tok_in;
		// first region that matches wins; later cells only pass it on
		if (!tok_in.hit && (sec_hit || nsec_hit)) begin
			tok_nxt.hit = 1'b1;
			tok_nxt.off = region_q.off + delta;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_out = tok_q;

endmodule

FILE: sv/secure_memory_map_decoder_unit.sv
// ----------------------------------------------------------------------------
// secure_memory_map_decoder_unit: flash / RAM / MMIO decoder with region table
// Decode request: the request is captured, the flash and RAM windows are
// registered, then the token walks the region chain one cell per cycle. The
// next request is taken only once the result has moved to the output
// register. Reset clears configuration, region count and total and the
// control state; region entries stay unwritten until appended.
// ----------------------------------------------------------------------------
module secure_memory_map_decoder_unit #(
	parameter int unsigned MAX_REGIONS = smmd_pkg::MAX_REGIONS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  smmd_pkg::req_t                  in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output smmd_pkg::rsp_t                  out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [smmd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                     cfg_data
);
	import smmd_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_REGIONS + 1);

	// configuration
	logic [31:0] flash_sec_base_q, flash_sec_len_q, flash_nsec_base_q, flash_nsec_len_q;
	logic [31:0] ram_sec_base_q, ram_sec_len_q, ram_nsec_base_q, ram_nsec_len_q;

	// region table bookkeeping
	logic [CNT_W-1:0] count_q;
	logic [32:0]      total_q;
	logic [33:0]      total_sum;
	logic [32:0]      total_nxt;
	region_t          new_region;

	// control
	st_t  state_q, state_nxt;
	logic in_fire, dec_fire, tbl_fire, app_fire, clr_fire;
	logic pre_en, run_done, out_load;

	// request under decode
	logic [1:0]  kind_q;
	logic [31:0] addr_q;
	logic [2:0]  sz_q;
	logic        size_ok_q;

	// first stage results
	logic        fl_sec, fl_nsec, rs_hit, rn_hit, fb_hit, tbl_empty;
	logic [32:0] total_sel;
	logic        alt_hit;
	logic [31:0] alt_off;
	logic        fl_hit_s1, fl_nsh_s1, alt_hit_s1;
	logic [31:0] fl_off_s1, alt_off_s1;

	// chain
	tok_t             tok_in  [MAX_REGIONS];
	tok_t             tok_out [MAX_REGIONS];
	logic [MAX_REGIONS-1:0] cell_wr;
	logic [MAX_REGIONS-1:0] cell_used;
	tok_t             chain_end;

	// result
	rsp_t res, fin_q, out_q;
	logic out_valid_q;
	logic is_wr, is_fe, ram_ok;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flash_sec_base_q  <= '0;
			flash_sec_len_q   <= '0;
			flash_nsec_base_q <= '0;
			flash_nsec_len_q  <= '0;
			ram_sec_base_q    <= '0;
			ram_sec_len_q     <= '0;
			ram_nsec_base_q   <= '0;
			ram_nsec_len_q    <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_FLASH_SEC_BASE:  flash_sec_base_q  <= cfg_data;
				CFG_FLASH_SEC_LEN:   flash_sec_len_q   <= cfg_data;
				CFG_FLASH_NSEC_BASE: flash_nsec_base_q <= cfg_data;
				CFG_FLASH_NSEC_LEN:  flash_nsec_len_q  <= cfg_data;
				CFG_RAM_SEC_BASE:    ram_sec_base_q    <= cfg_data;
				CFG_RAM_SEC_LEN:     ram_sec_len_q     <= cfg_data;
				CFG_RAM_NSEC_BASE:   ram_nsec_base_q   <= cfg_data;
				CFG_RAM_NSEC_LEN:    ram_nsec_len_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- control ----------------
	assign in_fire  = in_valid && in_ready;
	assign dec_fire = in_fire && (in_data.req_type == REQ_DECODE);
	assign tbl_fire = in_fire && (in_data.req_type != REQ_DECODE);
	assign app_fire = in_fire && (in_data.req_type == REQ_APPEND);
	assign clr_fire = in_fire && (in_data.req_type == REQ_CLEAR);
	assign chain_end = tok_out[MAX_REGIONS-1];

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (dec_fire) begin
					state_nxt = ST_PRE;
				end else if (tbl_fire) begin
					state_nxt = ST_FIN;
				end
			end
			ST_PRE: state_nxt = ST_RUN;
			ST_RUN: begin
				if (chain_end.live) begin
					state_nxt = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		pre_en   = 1'b0;
		run_done = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_PRE:  pre_en   = 1'b1;
			ST_RUN:  run_done = chain_end.live;
			ST_FIN:  out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// ---------------- region table ----------------
	assign total_sum = {1'b0, total_q} + {2'b0, in_data.region_len};
	assign total_nxt = total_sum[33] ? '1 : total_sum[32:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			total_q <= '0;
		end else if (clr_fire) begin
			count_q <= '0;
			total_q <= '0;
		end else if (app_fire && (count_q < CNT_W'(MAX_REGIONS))) begin
			count_q <= count_q + 1'b1;
			total_q <= total_nxt;
		end
	end

	assign new_region = '{
		sec_base:  in_data.region_sec_base,
		nsec_base: in_data.region_nsec_base,
		len:       in_data.region_len,
		off:       total_q[31:0]
	};

	// ---------------- request capture ----------------
	always_ff @(posedge clk) begin
		if (dec_fire) begin
			kind_q    <= in_data.access_kind;
			addr_q    <= in_data.addr;
			sz_q      <= (in_data.access_kind == KIND_FETCH) ? FETCH_BYTES
			                                                 : in_data.access_bytes;
			size_ok_q <= (in_data.access_bytes >= SIZE_MIN)
			          && (in_data.access_bytes <= SIZE_MAX);
		end
	end

	// ---------------- first stage: flash and RAM windows ----------------
	always_comb begin
		fl_sec    = in_window(addr_q, sz_q, flash_sec_base_q, flash_sec_len_q);
		fl_nsec   = in_window(addr_q, sz_q, flash_nsec_base_q, flash_nsec_len_q);
		rs_hit    = in_window(addr_q, sz_q, ram_sec_base_q, ram_sec_len_q);
		rn_hit    = in_window(addr_q, sz_q, ram_nsec_base_q, ram_nsec_len_q);
		tbl_empty = (count_q == '0);
		total_sel = tbl_empty ? {1'b0, ram_sec_len_q} : total_q;
		// zero-based fallback when both RAM bases are unset
		fb_hit    = (total_sel != '0) && (ram_sec_base_q == '0) && (ram_nsec_base_q == '0)
		         && (({1'b0, addr_q} + {30'd0, sz_q}) <= total_sel);
		alt_hit   = (tbl_empty && (rs_hit || rn_hit)) || fb_hit;
		if (tbl_empty && rs_hit) begin
			alt_off = addr_q - ram_sec_base_q;
		end else if (tbl_empty && rn_hit) begin
			alt_off = addr_q - ram_nsec_base_q;
		end else begin
			alt_off = addr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pre_en) begin
			fl_hit_s1  <= fl_sec || fl_nsec;
			fl_nsh_s1  <= !fl_sec && fl_nsec;
			fl_off_s1  <= fl_sec ? (addr_q - flash_sec_base_q) : (addr_q - flash_nsec_base_q);
			alt_hit_s1 <= alt_hit;
			alt_off_s1 <= alt_off;
		end
	end

	// ---------------- region chain ----------------
	assign tok_in[0] = '{live: pre_en, hit: 1'b0, off: '0};

	for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_cell
		if (g > 0) begin : g_link
			assign tok_in[g] = tok_out[g-1];
		end
		assign cell_wr[g]   = app_fire && (count_q == CNT_W'(g));
		assign cell_used[g] = count_q > CNT_W'(g);

		smmd_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.wr        (cell_wr[g]),
			.wr_region (new_region),
			.used      (cell_used[g]),
			.addr      (addr_q),
			.sz        (sz_q),
			.tok_in    (tok_in[g]),
			.tok_out   (tok_out[g])
		);
	end

	// ---------------- resolve ----------------
	always_comb begin
		is_wr  = (kind_q == KIND_WRITE);
		is_fe  = (kind_q == KIND_FETCH);
		ram_ok = !is_wr || (sz_q == SIZE_MIN) || (sz_q == SIZE_HALF) || (sz_q == SIZE_MAX);
		res    = '0;
		if (!is_wr && !size_ok_q) begin
			res.target = TGT_MMIO;
		end else if (fl_hit_s1) begin
			res.target         = TGT_FLASH;
			res.byte_offset    = fl_off_s1;
			res.flash_nsec_hit = fl_nsh_s1;
		end else if (ram_ok && (chain_end.hit || alt_hit_s1)) begin
			res.target      = TGT_RAM;
			res.byte_offset = chain_end.hit ? chain_end.off : alt_off_s1;
		end else if (is_fe) begin
			res.target = TGT_FAULT;
		end else begin
			res.target = TGT_MMIO;
			res.in_scs = is_wr && (addr_q >= SCS_LO) && (addr_q < SCS_HI);
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_fire) begin
			fin_q <= '0;
		end else if (run_done) begin
			fin_q <= res;
		end
	end

	// output register parts the result from the next request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= fin_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: sv/smmd_checker.sv
// ----------------------------------------------------------------------------
// smmd_checker: port-level checks of the memory map decoder
// Output consistency and one-request-at-a-time behavior.
// ----------------------------------------------------------------------------
module smmd_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input smmd_pkg::rsp_t out_data
);
	import smmd_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled response changed");

	a_nsh_flash: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.flash_nsec_hit |-> out_data.target == TGT_FLASH)
		else $error("non-secure flash flag without flash target");

	a_scs_mmio: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.in_scs |-> out_data.target == TGT_MMIO)
		else $error("SCS flag without MMIO target");

	a_no_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.target == TGT_MMIO || out_data.target == TGT_FAULT)
		|-> out_data.byte_offset == '0)
		else $error("offset on MMIO or fault response");

	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while another is in work");

endmodule

bind secure_memory_map_decoder_unit smmd_checker u_smmd_checker (.*);
